// ----- hw/rtl/aabb_pkg.sv -----
// Shared types and constants for the box overlap marker: store sizes, function
// codes, request and response words, and the controller-datapath interface.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aabb_pkg;

   localparam int MAX_STATIC  = 64;
   localparam int MAX_DYNAMIC = 64;

   localparam int SIDX_W = (MAX_STATIC > 1) ? $clog2(MAX_STATIC) : 1;
   localparam int DIDX_W = (MAX_DYNAMIC > 1) ? $clog2(MAX_DYNAMIC) : 1;
   localparam int SCNT_W = $clog2(MAX_STATIC + 1);
   localparam int DCNT_W = $clog2(MAX_DYNAMIC + 1);

   localparam int POS_W   = 32;
   localparam int SIZE_W  = 16;
   localparam int COLOR_W = 16;
   localparam int RIDX_W  = 6;
   localparam int FRAC_W  = 8;
   localparam int SUM_W   = POS_W + 1;

   localparam logic [1:0] FUNC_LOAD_STATIC  = 2'd0;
   localparam logic [1:0] FUNC_LOAD_DYNAMIC = 2'd1;
   localparam logic [1:0] FUNC_START        = 2'd2;

   typedef struct packed {
      logic [1:0]              func;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [SIZE_W-1:0]       box_width;
      logic [SIZE_W-1:0]       box_height;
      logic [COLOR_W-1:0]      prior_color;
   } req_type;

   typedef struct packed {
      logic [RIDX_W-1:0]  rect_index;
      logic [COLOR_W-1:0] color;
      logic               hit;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [SIZE_W-1:0]       w;
      logic [SIZE_W-1:0]       h;
   } geom_type;

   typedef struct packed {
      logic load_static;
      logic load_dynamic;
      logic begin_pass;
      logic prep;
      logic scan;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic static_empty;
      logic dynamic_empty;
      logic overlap;
      logic scan_done;
      logic last_static;
   } dp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PREP,
      ST_SCAN,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/aabb_collision_marker_core.sv -----
// Box overlap marker: a static and a dynamic rectangle store tested pairwise
// with an inclusive overlap test that recolours every static rectangle hit.
// Depends on aabb_pkg, aabb_ctrl and aabb_dp.
//
// A request word is taken at a clock edge with start high and busy low.
// Load words (static or dynamic) may follow one another in every cycle; a load
// into a full store is dropped. A start word with static rectangles loaded
// raises busy for the collision pass. For each static rectangle the pass reads
// the static entry, prepares the scan, tests dynamic rectangles one after
// another (the scan stops at the first hit, so between one and the dynamic
// count are tested, none when that store is empty), and emits; the response
// word appears on rsp_word in the cycle after the emit, with rsp_valid high
// for exactly that cycle. The dynamic store's read port and the single shared
// comparator make the scan test one dynamic rectangle at a time. Words arrive
// in load order, the last marked. The receiver cannot stall, so responses are
// never held back. Synchronous reset empties both stores and clears new_color;
// stored entries are not cleared. csr_we writes new_color from csr_wdata.
`timescale 1ns / 1ps
`default_nettype none

module aabb_collision_marker_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire aabb_pkg::req_type req_word,
   input  wire logic              csr_we,
   input  wire logic [15:0]       csr_wdata,
   output logic                   rsp_valid,
   output aabb_pkg::rsp_type      rsp_word
);
   import aabb_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   aabb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .func   (req_word.func),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   aabb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_word),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_word)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/aabb_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module aabb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                          clock,
   input  wire logic                                          we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
   input  wire logic [WIDTH-1:0]                              wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
   output logic      [WIDTH-1:0]                              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/aabb_ctrl.sv -----
// Sequencer for the box overlap marker: decodes request words and steps the
// datapath through each collision pass. Depends on aabb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aabb_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [1:0]             func,
   input  wire aabb_pkg::dp_status_type status,
   output aabb_pkg::ctrl_cmd_type      cmd,
   output logic                        busy
);
   import aabb_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (func)
                  FUNC_LOAD_STATIC:  cmd.load_static  = 1'b1;
                  FUNC_LOAD_DYNAMIC: cmd.load_dynamic = 1'b1;
                  FUNC_START: begin
                     if (!status.static_empty) begin
                        cmd.begin_pass = 1'b1;
                        state_in       = ST_FETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // The static entry is being read; its data appear in the next state.
         ST_FETCH: state_in = ST_PREP;
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.dynamic_empty ? ST_EMIT : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.overlap || status.scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = status.last_static ? ST_IDLE : ST_FETCH;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/aabb_dp.sv -----
// Datapath of the box overlap marker: rectangle stores, counts, pass indexes,
// the overlap comparators and the response register. Depends on aabb_pkg and
// aabb_ram.
`timescale 1ns / 1ps
`default_nettype none

module aabb_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire aabb_pkg::req_type      req,
   input  wire logic                   csr_we,
   input  wire logic [15:0]            csr_wdata,
   input  wire aabb_pkg::ctrl_cmd_type cmd,
   output aabb_pkg::dp_status_type     status,
   output logic                        rsp_valid,
   output aabb_pkg::rsp_type           rsp
);
   import aabb_pkg::*;

   logic [SCNT_W-1:0]  sc_ff, sc_in;
   logic [DCNT_W-1:0]  dc_ff, dc_in;
   logic [SIDX_W-1:0]  i_ff, i_in;
   logic [DCNT_W-1:0]  j_ff, j_in;
   logic               hit_ff, hit_in;
   logic [COLOR_W-1:0] new_color_ff, new_color_in;
   logic               valid_ff, valid_in;
   rsp_type            rsp_ff, rsp_in;

   geom_type           req_geom, s_geom, d_geom;
   logic               s_full, d_full;
   logic               s_we, d_we, c_we;
   logic [SIDX_W-1:0]  c_waddr;
   logic [COLOR_W-1:0] c_wdata, c_rdata;
   logic [DIDX_W-1:0]  d_raddr;

   logic signed [SUM_W-1:0] sx, sy, sx_end, sy_end, dx, dy, dx_end, dy_end;

   assign req_geom = '{x: req.pos_x, y: req.pos_y, w: req.box_width, h: req.box_height};
   assign s_full   = (sc_ff == SCNT_W'(MAX_STATIC));
   assign d_full   = (dc_ff == DCNT_W'(MAX_DYNAMIC));
   assign s_we     = cmd.load_static && !s_full;
   assign d_we     = cmd.load_dynamic && !d_full;
   assign c_we     = s_we || (cmd.emit && hit_ff);
   assign c_waddr  = cmd.emit ? i_ff : sc_ff[SIDX_W-1:0];
   assign c_wdata  = cmd.emit ? new_color_ff : req.prior_color;
   assign d_raddr  = cmd.prep ? '0 : j_ff[DIDX_W-1:0];

   aabb_ram #(.WIDTH($bits(geom_type)), .DEPTH(MAX_STATIC)) u_static_geom (
      .clock (clock),
      .we    (s_we),
      .waddr (sc_ff[SIDX_W-1:0]),
      .wdata (req_geom),
      .raddr (i_ff),
      .rdata (s_geom)
   );

   aabb_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_STATIC)) u_static_color (
      .clock (clock),
      .we    (c_we),
      .waddr (c_waddr),
      .wdata (c_wdata),
      .raddr (i_ff),
      .rdata (c_rdata)
   );

   aabb_ram #(.WIDTH($bits(geom_type)), .DEPTH(MAX_DYNAMIC)) u_dynamic_geom (
      .clock (clock),
      .we    (d_we),
      .waddr (dc_ff[DIDX_W-1:0]),
      .wdata (req_geom),
      .raddr (d_raddr),
      .rdata (d_geom)
   );

   // Edges at 33 bits so that a position plus a span never wraps.
   assign sx     = {s_geom.x[POS_W-1], s_geom.x};
   assign sy     = {s_geom.y[POS_W-1], s_geom.y};
   assign sx_end = sx + {{(SUM_W-SIZE_W-FRAC_W){1'b0}}, s_geom.w, {FRAC_W{1'b0}}};
   assign sy_end = sy + {{(SUM_W-SIZE_W-FRAC_W){1'b0}}, s_geom.h, {FRAC_W{1'b0}}};
   assign dx     = {d_geom.x[POS_W-1], d_geom.x};
   assign dy     = {d_geom.y[POS_W-1], d_geom.y};
   assign dx_end = dx + {{(SUM_W-SIZE_W-FRAC_W){1'b0}}, d_geom.w, {FRAC_W{1'b0}}};
   assign dy_end = dy + {{(SUM_W-SIZE_W-FRAC_W){1'b0}}, d_geom.h, {FRAC_W{1'b0}}};

   always_comb begin
      status.static_empty  = (sc_ff == '0);
      status.dynamic_empty = (dc_ff == '0);
      // Touching edges count as overlap, so only strict separation rejects.
      status.overlap       = !((dy_end < sy) || (dy > sy_end) ||
                               (dx_end < sx) || (dx > sx_end));
      status.scan_done     = (j_ff == dc_ff);
      status.last_static   = ((SCNT_W'(i_ff) + SCNT_W'(1)) == sc_ff);
   end

   always_comb begin
      sc_in        = s_we ? sc_ff + SCNT_W'(1) : sc_ff;
      dc_in        = d_we ? dc_ff + DCNT_W'(1) : dc_ff;
      new_color_in = csr_we ? csr_wdata : new_color_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      hit_in       = hit_ff;
      if (cmd.begin_pass) begin
         i_in = '0;
      end else if (cmd.emit) begin
         i_in = i_ff + SIDX_W'(1);
      end
      // The prep cycle reads dynamic entry zero, so the scan starts at one.
      if (cmd.prep) begin
         j_in   = DCNT_W'(1);
         hit_in = 1'b0;
      end else if (cmd.scan) begin
         j_in = j_ff + DCNT_W'(1);
         if (status.overlap) begin
            hit_in = 1'b1;
         end
      end
      valid_in          = cmd.emit;
      rsp_in.rect_index = RIDX_W'(i_ff);
      rsp_in.color      = hit_ff ? new_color_ff : c_rdata;
      rsp_in.hit        = hit_ff;
      rsp_in.last       = status.last_static;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff        <= '0;
         dc_ff        <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         hit_ff       <= 1'b0;
         new_color_ff <= '0;
         valid_ff     <= 1'b0;
      end else begin
         sc_ff        <= sc_in;
         dc_ff        <= dc_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         hit_ff       <= hit_in;
         new_color_ff <= new_color_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ----- tb/aabb_collision_marker_checker.sv -----
`timescale 1ns / 1ps

// Checker for the box overlap marker: watches the request, response and colour
// register ports, predicts every response word and compares it with the one seen.
// Depends on aabb_pkg.
module aabb_collision_marker_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire aabb_pkg::req_type req,
   input  wire logic              csr_we,
   input  wire logic [15:0]       csr_wdata,
   input  wire logic              rsp_valid,
   input  wire aabb_pkg::rsp_type rsp,
   output int                     fail_count,
   output int                     outstanding,
   output int                     checked
);
   import aabb_pkg::*;

   localparam int REPORT_LIMIT = 10;

   req_type            static_box    [MAX_STATIC];
   logic [COLOR_W-1:0] static_colour [MAX_STATIC];
   req_type            dynamic_box   [MAX_DYNAMIC];
   int                 static_loaded;
   int                 dynamic_loaded;
   logic [COLOR_W-1:0] hit_colour;
   rsp_type            marks_due [$];
   rsp_type            want;
   int                 mismatches;
   int                 compared;

   // A size in whole units becomes a Q24.8 span, held at the width of an edge sum.
   function automatic logic signed [SUM_W-1:0] span_of(logic [SIZE_W-1:0] units);
      return $signed({{(SUM_W-SIZE_W-FRAC_W){1'b0}}, units, {FRAC_W{1'b0}}});
   endfunction

   // Boxes meet unless one lies strictly beyond the other on some axis.
   function automatic logic boxes_meet(req_type s, req_type d);
      logic signed [SUM_W-1:0] sx, sy, dx, dy;
      sx = $signed(s.pos_x);
      sy = $signed(s.pos_y);
      dx = $signed(d.pos_x);
      dy = $signed(d.pos_y);
      return !((dy + span_of(d.box_height) < sy) || (dy > sy + span_of(s.box_height)) ||
               (dx + span_of(d.box_width) < sx)  || (dx > sx + span_of(s.box_width)));
   endfunction

   task automatic predict_marks(req_type w);
      rsp_type mark;
      logic    hit;
      int      i, j;
      case (w.func)
         FUNC_LOAD_STATIC: begin
            if (static_loaded < MAX_STATIC) begin
               static_box[static_loaded]    = w;
               static_colour[static_loaded] = w.prior_color;
               static_loaded++;
            end
         end
         FUNC_LOAD_DYNAMIC: begin
            if (dynamic_loaded < MAX_DYNAMIC) begin
               dynamic_box[dynamic_loaded] = w;
               dynamic_loaded++;
            end
         end
         FUNC_START: begin
            for (i = 0; i < static_loaded; i++) begin
               hit = 1'b0;
               for (j = 0; j < dynamic_loaded && !hit; j++)
                  hit = boxes_meet(static_box[i], dynamic_box[j]);
               // The stored colour is updated, so a later pass starts from it.
               if (hit)
                  static_colour[i] = hit_colour;
               mark.rect_index = i[RIDX_W-1:0];
               mark.color      = static_colour[i];
               mark.hit        = hit;
               mark.last       = (i + 1 == static_loaded);
               marks_due.push_back(mark);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         static_loaded  = 0;
         dynamic_loaded = 0;
         hit_colour     = '0;
         marks_due.delete();
      end else begin
         // A response word seen at this edge belongs to work taken earlier,
         // so it is matched before any new request word is predicted.
         if (rsp_valid) begin
            if (marks_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected response word: index %0d colour %h hit %b last %b",
                           $time, rsp.rect_index, rsp.color, rsp.hit, rsp.last);
            end else begin
               want = marks_due.pop_front();
               compared++;
               if (rsp.rect_index !== want.rect_index || rsp.color !== want.color ||
                   rsp.hit !== want.hit || rsp.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"%0t: response mismatch: expected index %0d colour %h hit %b ",
                               "last %b, got index %0d colour %h hit %b last %b"},
                              $time, want.rect_index, want.color, want.hit, want.last,
                              rsp.rect_index, rsp.color, rsp.hit, rsp.last);
               end
            end
         end
         if (csr_we)
            hit_colour = csr_wdata;
         if (start && !busy)
            predict_marks(req);
      end
      fail_count  <= mismatches;
      outstanding <= marks_due.size();
      checked     <= compared;
   end

endmodule

// ----- tb/aabb_collision_marker_core_tb.sv -----
`timescale 1ns / 1ps

// Testbench top for the box overlap marker: clock, reset, request and colour
// register stimulus, watchdog and verdict.
// Depends on aabb_pkg, aabb_collision_marker_core and aabb_collision_marker_checker.
module aabb_collision_marker_core_tb;
   import aabb_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int WORD_TARGET  = 320;
   localparam int COLOUR_EVERY = 40;
   localparam int DRAIN_CYCLES = 72;
   localparam int QUIET_LIMIT  = 4000;

   logic        clock;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   req_type     req       = '0;
   logic        csr_we    = 1'b0;
   logic [15:0] csr_wdata = '0;
   logic        busy;
   logic        rsp_valid;
   rsp_type     rsp;
   int          fail_count;
   int          outstanding;
   int          checked;
   int          idle_pct;
   int          statics_sent;
   int          dynamics_sent;
   int          passes_sent;
   int          counted;
   int          colour_writes;

   aabb_collision_marker_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp)
   );

   aabb_collision_marker_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req         (req),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .checked     (checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic req_type box_word(logic [1:0] func, logic [31:0] x, logic [31:0] y,
                                        logic [15:0] w, logic [15:0] h, logic [15:0] c);
      req_type word;
      word.func        = func;
      word.pos_x       = x;
      word.pos_y       = y;
      word.box_width   = w;
      word.box_height  = h;
      word.prior_color = c;
      return word;
   endfunction

   // Most boxes sit on a coarse grid near the origin so that edges meet often;
   // the rest are spread over the whole range of every field.
   function automatic req_type rect_word(logic [1:0] func);
      int gx, gy;
      if ($urandom_range(99) < 78) begin
         gx = $urandom_range(40);
         gy = $urandom_range(40);
         gx = (gx - 20) * 256;
         gy = (gy - 20) * 256;
         if ($urandom_range(3) == 0)
            gx = gx + $urandom_range(255);
         if ($urandom_range(3) == 0)
            gy = gy + $urandom_range(255);
         return box_word(func, gx, gy, 16'($urandom_range(10)), 16'($urandom_range(10)),
                         16'($urandom));
      end
      return box_word(func, $urandom, $urandom, 16'($urandom), 16'($urandom),
                      16'($urandom));
   endfunction

   // Start stays high from one word to the next unless an idle cycle comes between.
   task automatic send(req_type word);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req   <= word;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      case (word.func)
         FUNC_LOAD_STATIC: begin
            if (statics_sent < MAX_STATIC)
               statics_sent++;
         end
         FUNC_LOAD_DYNAMIC: begin
            if (dynamics_sent < MAX_DYNAMIC)
               dynamics_sent++;
         end
         FUNC_START: passes_sent++;
         default: ;
      endcase
      counted++;
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || busy)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic write_colour(logic [15:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      colour_writes++;
   endtask

   initial begin : stimulus
      req_type word;
      int      pick;
      int      base;
      int      next_colour_at;
      int      colour_turn;
      idle_pct    = 9;
      colour_turn = 0;
      repeat (8)
         @(posedge clock);
      reset <= 1'b0;
      write_colour(16'hA5C3);

      send(rect_word(FUNC_UNUSED));
      // A pass with nothing loaded gives no response word.
      send(rect_word(FUNC_START));
      send(box_word(FUNC_LOAD_STATIC, 32'h8000_0000, 32'h8000_0000,
                    16'hFFFF, 16'hFFFF, 16'hFFFF));
      send(box_word(FUNC_LOAD_STATIC, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    16'h0000, 16'h0000, 16'h0000));
      send(box_word(FUNC_LOAD_STATIC, 32'd0, 32'd0, 16'd4, 16'd4, 16'h1234));
      // No dynamic boxes yet: every static box keeps its colour.
      send(rect_word(FUNC_START));
      // Left edge lies exactly on the right edge of the third static box.
      send(box_word(FUNC_LOAD_DYNAMIC, 32'd1024, 32'd0, 16'd2, 16'd2, 16'($urandom)));
      send(rect_word(FUNC_START));
      send(rect_word(FUNC_START));
      // One Q24.8 step beyond the right edge of the first dynamic box.
      send(box_word(FUNC_LOAD_STATIC, 32'd1537, 32'd0, 16'd1, 16'd1, 16'h0F0F));
      // Covers the top corner of the range; its edge sums pass the 32-bit limit.
      send(box_word(FUNC_LOAD_DYNAMIC, 32'h7FFF_FF00, 32'h7FFF_FF00,
                    16'hFFFF, 16'hFFFF, 16'($urandom)));
      // One step below the third static box.
      send(box_word(FUNC_LOAD_DYNAMIC, 32'd0, 32'd1025, 16'd8, 16'd2, 16'($urandom)));
      // A point on the bottom edge of the first static box.
      send(box_word(FUNC_LOAD_DYNAMIC, 32'h8000_0000, 32'h80FF_FF00,
                    16'd0, 16'd0, 16'($urandom)));
      send(rect_word(FUNC_START));
      settle();
      write_colour(16'hFFFF);

      base           = counted;
      next_colour_at = counted + COLOUR_EVERY;
      while (counted < WORD_TARGET) begin
         if (counted >= next_colour_at) begin
            settle();
            case (colour_turn % 3)
               0:       write_colour(16'h0000);
               1:       write_colour(16'($urandom_range(65535)));
               default: write_colour(16'hFFFF);
            endcase
            colour_turn++;
            next_colour_at = counted + COLOUR_EVERY;
         end
         if (counted - base < (WORD_TARGET - base) / 3)
            idle_pct = 9;
         else if (counted - base < 2 * (WORD_TARGET - base) / 3)
            idle_pct = 73;
         else
            idle_pct = 0;
         pick = $urandom_range(99);
         if (pick < 35)
            word = rect_word(FUNC_LOAD_STATIC);
         else if (pick < 70)
            word = rect_word(FUNC_LOAD_DYNAMIC);
         else if (pick < 93)
            word = rect_word(FUNC_START);
         else
            word = rect_word(FUNC_UNUSED);
         send(word);
      end
      settle();

      $display("Covered %0d accepted words, %0d collision passes and %0d colour writes.",
               counted, passes_sent, colour_writes);
      $display("%0d response words were checked against the prediction.", checked);
      if (fail_count == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid || csr_we)
            quiet = 0;
         else
            quiet++;
      end
      $display("Watchdog: no handshake for %0d cycles.", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
